// ===== sv/kppa_pkg.sv =====
package kppa_pkg;

  localparam int POOL_SLOTS = 8;
  localparam int MAX_UNITS  = 256;
  localparam int PAGE_CAP   = 256;

  localparam int SLOT_W = 3;
  localparam int PAGE_W = 8;
  localparam int SIZE_W = 9;
  localparam int FMT_W  = 16;
  localparam int BASE_W = 8;
  localparam int CNT_W  = $clog2(PAGE_CAP + 1);
  localparam int DVD_W  = $clog2(MAX_UNITS + 1);
  localparam int DCNT_W = $clog2(DVD_W + 1);
  localparam int ADDR_W = SLOT_W + PAGE_W;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_OPEN,
    S_POP,
    S_READ
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    pick;
    logic    push;
    logic    div_start;
    logic    open;
    logic    pop;
    logic    load;
    logic    grant;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_bad;
    logic match_found;
    logic slot_found;
    logic free_ok;
    logic div_done;
  } stat_t;

endpackage

// ===== sv/kppa_div.sv =====
module kppa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [kppa_pkg::SIZE_W-1:0]  divisor,
  output logic                         done,
  output logic [kppa_pkg::CNT_W-1:0]   quotient
);
  import kppa_pkg::*;

  logic [SIZE_W-1:0] rem;
  logic [DVD_W-1:0]  quo;
  logic [DCNT_W-1:0] cnt;
  logic              running;
  logic [SIZE_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[DVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
    end else if (running && cnt == DCNT_W'(1)) begin
      running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= DVD_W'(MAX_UNITS);
      cnt <= DCNT_W'(DVD_W);
    end else if (running) begin
      rem <= fits ? SIZE_W'(trial - {1'b0, divisor}) : SIZE_W'(trial);
      quo <= {quo[DVD_W-2:0], fits};
      cnt <= cnt - DCNT_W'(1);
    end
  end

  assign done     = !running;
  assign quotient = (32'(quo) > PAGE_CAP) ? CNT_W'(PAGE_CAP) : CNT_W'(quo);

endmodule

// ===== sv/kppa_dp.sv =====
module kppa_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  kppa_pkg::cmd_t               cmd,
  output kppa_pkg::stat_t              stat,
  input  logic                         kind,
  input  logic [kppa_pkg::SIZE_W-1:0]  page_elems,
  input  logic [kppa_pkg::FMT_W-1:0]   format,
  input  logic [kppa_pkg::SLOT_W-1:0]  pool_slot,
  input  logic [kppa_pkg::PAGE_W-1:0]  page_number,
  output kppa_pkg::status_t            status,
  output logic [kppa_pkg::SLOT_W-1:0]  granted_pool,
  output logic [kppa_pkg::PAGE_W-1:0]  granted_page,
  output logic [kppa_pkg::BASE_W-1:0]  base_index
);
  import kppa_pkg::*;

  logic              r_kind;
  logic [SIZE_W-1:0] r_size;
  logic [FMT_W-1:0]  r_fmt;
  logic [SLOT_W-1:0] r_slot;
  logic [PAGE_W-1:0] r_page;

  logic              in_use    [POOL_SLOTS];
  logic [SIZE_W-1:0] slot_size [POOL_SLOTS];
  logic [FMT_W-1:0]  slot_fmt  [POOL_SLOTS];
  logic [CNT_W-1:0]  total     [POOL_SLOTS];
  logic [CNT_W-1:0]  count     [POOL_SLOTS];
  logic [CNT_W-1:0]  low_mark  [POOL_SLOTS];

  logic [PAGE_W-1:0] stack_mem [2**ADDR_W];
  logic [PAGE_W-1:0] rd_data;

  logic [SLOT_W-1:0] cur_slot;
  logic              use_mark;
  logic [PAGE_W-1:0] mark_page;

  logic              match_found;
  logic [SLOT_W-1:0] match_idx;
  logic              slot_found;
  logic [SLOT_W-1:0] free_idx;
  logic              free_ok;
  logic              div_done;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  cur_cm1;
  logic [PAGE_W-1:0] pg;
  logic [SIZE_W+PAGE_W-1:0] prod;

  kppa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .divisor  (r_size),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_kind <= kind;
      r_size <= page_elems;
      r_fmt  <= format;
      r_slot <= pool_slot;
      r_page <= page_number;
    end
  end

  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    slot_found  = 1'b0;
    free_idx    = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (in_use[i] && slot_size[i] == r_size && slot_fmt[i] == r_fmt &&
          count[i] != '0) begin
        match_found = 1'b1;
        match_idx   = SLOT_W'(i);
      end
      if (!in_use[i]) begin
        slot_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign free_ok = (32'(r_slot) < POOL_SLOTS) && in_use[r_slot] &&
                   ({1'b0, r_page} < total[r_slot]) &&
                   (count[r_slot] < total[r_slot]);

  assign stat.is_free     = r_kind == KIND_FREE;
  assign stat.size_bad    = r_size == '0 || 32'(r_size) > MAX_UNITS;
  assign stat.match_found = match_found;
  assign stat.slot_found  = slot_found;
  assign stat.free_ok     = free_ok;
  assign stat.div_done    = div_done;

  assign cur_cnt = count[cur_slot];
  assign cur_cm1 = cur_cnt - CNT_W'(1);

  // pages below the low mark were never popped since open and still hold their index
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        in_use[i] <= 1'b0;
        count[i]  <= '0;
      end
    end else if (cmd.push) begin
      count[r_slot] <= count[r_slot] + CNT_W'(1);
    end else if (cmd.open) begin
      in_use[cur_slot] <= 1'b1;
      count[cur_slot]  <= div_q;
    end else if (cmd.pop) begin
      count[cur_slot] <= cur_cm1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      cur_slot <= match_found ? match_idx : free_idx;
    end
    if (cmd.open) begin
      slot_size[cur_slot] <= r_size;
      slot_fmt[cur_slot]  <= r_fmt;
      total[cur_slot]     <= div_q;
      low_mark[cur_slot]  <= div_q;
    end
    if (cmd.pop) begin
      use_mark  <= cur_cnt == low_mark[cur_slot];
      mark_page <= cur_cm1[PAGE_W-1:0];
      if (cur_cnt == low_mark[cur_slot]) begin
        low_mark[cur_slot] <= cur_cm1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[{r_slot, count[r_slot][PAGE_W-1:0]}] <= r_page;
    end
    rd_data <= stack_mem[{cur_slot, cur_cm1[PAGE_W-1:0]}];
  end

  assign pg   = use_mark ? mark_page : rd_data;
  assign prod = r_size * pg;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status <= cmd.res_status;
      if (cmd.grant) begin
        granted_pool <= cur_slot;
        granted_page <= pg;
        base_index   <= prod[BASE_W-1:0];
      end else begin
        granted_pool <= '0;
        granted_page <= '0;
        base_index   <= '0;
      end
    end
  end

endmodule

// ===== sv/kppa_ctrl.sv =====
module kppa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output kppa_pkg::cmd_t  cmd,
  input  kppa_pkg::stat_t stat
);
  import kppa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.load;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_CHECK;
      S_CHECK: begin
        if (stat.is_free || stat.size_bad) begin
          state_next = S_IDLE;
        end else if (stat.match_found) begin
          state_next = S_POP;
        end else if (!stat.slot_found) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV:   if (stat.div_done) state_next = S_OPEN;
      S_OPEN:  state_next = S_POP;
      S_POP:   state_next = S_READ;
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_OK;
    unique case (state)
      S_IDLE:  cmd.latch = start;
      S_CHECK: begin
        cmd.pick = 1'b1;
        if (stat.is_free) begin
          cmd.load = 1'b1;
          if (stat.free_ok) begin
            cmd.push = 1'b1;
          end else begin
            cmd.res_status = ST_BAD_FREE;
          end
        end else if (stat.size_bad) begin
          cmd.load       = 1'b1;
          cmd.res_status = ST_BAD_SIZE;
        end else if (stat.match_found) begin
          cmd.load = 1'b0;
        end else if (!stat.slot_found) begin
          cmd.load       = 1'b1;
          cmd.res_status = ST_NO_SLOT;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_DIV:   cmd.pick = 1'b0;
      S_OPEN:  cmd.open = 1'b1;
      S_POP:   cmd.pop = 1'b1;
      S_READ: begin
        cmd.load  = 1'b1;
        cmd.grant = 1'b1;
      end
      default: cmd.pick = 1'b0;
    endcase
  end

  assign busy = state != S_IDLE;

endmodule

// ===== sv/keyed_pool_page_allocator.sv =====
// channel  | handshake       | fields
// ---------+-----------------+-----------------------------------------------------
// request  | start, busy     | kind, page_elems, format, pool_slot, page_number
// result   | done            | status, granted_pool, granted_page, base_index
//
// A request is taken when start is high and busy is low; one result per request.
// Free, bad size, table full: result loaded in the check state. Alloc from an open
// pool: check, pop, read; a new pool adds divide (bit-serial page count divider), open.
// Synchronous reset empties the pool table; the stack memory needs no clearing.
// done is high one cycle; results cannot be held off.
module keyed_pool_page_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [kppa_pkg::SIZE_W-1:0]  page_elems,
  input  logic [kppa_pkg::FMT_W-1:0]   format,
  input  logic [kppa_pkg::SLOT_W-1:0]  pool_slot,
  input  logic [kppa_pkg::PAGE_W-1:0]  page_number,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [kppa_pkg::SLOT_W-1:0]  granted_pool,
  output logic [kppa_pkg::PAGE_W-1:0]  granted_page,
  output logic [kppa_pkg::BASE_W-1:0]  base_index
);
  import kppa_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  status_t status_q;

  kppa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  kppa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .page_elems   (page_elems),
    .format       (format),
    .pool_slot    (pool_slot),
    .page_number  (page_number),
    .status       (status_q),
    .granted_pool (granted_pool),
    .granted_page (granted_page),
    .base_index   (base_index)
  );

  assign status = status_q;

endmodule

// ===== sv/kppa_checker.sv =====
module kppa_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic [2:0] granted_pool,
  input logic [7:0] granted_page,
  input logic [7:0] base_index
);
  import kppa_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held more than one cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> granted_pool == '0 && granted_page == '0 &&
    base_index == '0)
    else $error("error result carries nonzero grant fields");

  a_reset: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("reset did not clear control");

endmodule

bind keyed_pool_page_allocator kppa_checker u_kppa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .granted_pool (granted_pool),
  .granted_page (granted_page),
  .base_index   (base_index)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import kppa_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic              kind;
    logic [SIZE_W-1:0] page_elems;
    logic [FMT_W-1:0]  format;
    logic [SLOT_W-1:0] pool_slot;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] pool;
    logic [PAGE_W-1:0] page;
    logic [BASE_W-1:0] base;
  } grant_t;

  typedef struct {
    req_t   req;
    bit     typed;
    grant_t want;
  } dir_row_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] page;
  } page_ref_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              kind = 1'b0;
  logic [SIZE_W-1:0] page_elems = '0;
  logic [FMT_W-1:0]  format = '0;
  logic [SLOT_W-1:0] pool_slot = '0;
  logic [PAGE_W-1:0] page_number = '0;
  logic              done;
  logic [1:0]        status;
  logic [SLOT_W-1:0] granted_pool;
  logic [PAGE_W-1:0] granted_page;
  logic [BASE_W-1:0] base_index;

  keyed_pool_page_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .page_elems   (page_elems),
    .format       (format),
    .pool_slot    (pool_slot),
    .page_number  (page_number),
    .done         (done),
    .status       (status),
    .granted_pool (granted_pool),
    .granted_page (granted_page),
    .base_index   (base_index)
  );

  always #5 clk = ~clk;

  // shadow of the pool table
  bit                pool_in_use [POOL_SLOTS];
  logic [SIZE_W-1:0] pool_size   [POOL_SLOTS];
  logic [FMT_W-1:0]  pool_fmt    [POOL_SLOTS];
  int                pool_pages  [POOL_SLOTS];
  int                pool_avail  [POOL_SLOTS];
  logic [PAGE_W-1:0] pool_stack  [POOL_SLOTS][PAGE_CAP];

  grant_t    pending_grants[$];
  page_ref_t held_pages[$];
  dir_row_t  dir_rows[$];
  int        errors = 0;
  int        quiet_cycles = 0;

  function automatic grant_t predict_grant(req_t r);
    grant_t    g;
    page_ref_t held;
    int        s;
    int        i;
    int        n;
    int        prod;
    g.status = ST_OK;
    g.pool = '0;
    g.page = '0;
    g.base = '0;
    if (r.kind == KIND_ALLOC) begin
      if (r.page_elems == 0 || r.page_elems > MAX_UNITS) begin
        g.status = ST_BAD_SIZE;
      end else begin
        s = -1;
        for (i = POOL_SLOTS - 1; i >= 0; i--)
          if (pool_in_use[i] && pool_size[i] == r.page_elems &&
              pool_fmt[i] == r.format && pool_avail[i] != 0)
            s = i;
        if (s < 0) begin
          for (i = POOL_SLOTS - 1; i >= 0; i--)
            if (!pool_in_use[i]) s = i;
          if (s >= 0) begin
            n = MAX_UNITS / int'(r.page_elems);
            if (n > PAGE_CAP) n = PAGE_CAP;
            pool_in_use[s] = 1'b1;
            pool_size[s] = r.page_elems;
            pool_fmt[s] = r.format;
            pool_pages[s] = n;
            pool_avail[s] = n;
            for (i = 0; i < n; i++) pool_stack[s][i] = i[PAGE_W-1:0];
          end
        end
        if (s < 0) begin
          g.status = ST_NO_SLOT;
        end else begin
          pool_avail[s]--;
          g.pool = s[SLOT_W-1:0];
          g.page = pool_stack[s][pool_avail[s]];
          prod = int'(r.page_elems) * int'(g.page);
          g.base = prod[BASE_W-1:0];
          held.slot = g.pool;
          held.page = g.page;
          held_pages.insert(held_pages.size(), held);
        end
      end
    end else begin
      s = int'(r.pool_slot);
      if (s >= POOL_SLOTS || !pool_in_use[s] || int'(r.page_number) >= pool_pages[s] ||
          pool_avail[s] >= pool_pages[s]) begin
        g.status = ST_BAD_FREE;
      end else begin
        pool_stack[s][pool_avail[s]] = r.page_number;
        pool_avail[s]++;
      end
    end
    return g;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   sel;
    int   s;
    int   idx;
    r.kind = KIND_ALLOC;
    r.page_elems = SIZE_W'($urandom_range(511));
    r.format = FMT_W'($urandom);
    r.pool_slot = SLOT_W'($urandom);
    r.page_number = PAGE_W'($urandom);
    sel = $urandom_range(99);
    if (sel < 55) begin
      s = $urandom_range(POOL_SLOTS - 1);
      r.page_elems = pool_in_use[s] ? pool_size[s] : SIZE_W'($urandom_range(MAX_UNITS, 1));
      if (pool_in_use[s]) r.format = pool_fmt[s];
    end else if (sel < 62) begin
      r.page_elems = SIZE_W'($urandom_range(MAX_UNITS, 1));
    end else if (sel < 67) begin
      r.page_elems = ($urandom_range(1) == 0) ? '0 :
                     SIZE_W'($urandom_range(511, MAX_UNITS + 1));
    end else begin
      r.kind = KIND_FREE;
      if (sel < 87 && held_pages.size() != 0) begin
        idx = $urandom_range(held_pages.size() - 1);
        r.pool_slot = held_pages[idx].slot;
        r.page_number = held_pages[idx].page;
        held_pages.delete(idx);
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic add_row(input logic k, input int sz, input int fmt, input int sl,
                         input int pg, input bit typed, input status_t st,
                         input int gpool, input int gpage, input int gbase);
    dir_row_t row;
    row.req.kind = k;
    row.req.page_elems = SIZE_W'(sz);
    row.req.format = FMT_W'(fmt);
    row.req.pool_slot = SLOT_W'(sl);
    row.req.page_number = PAGE_W'(pg);
    row.typed = typed;
    row.want.status = st;
    row.want.pool = SLOT_W'(gpool);
    row.want.page = PAGE_W'(gpage);
    row.want.base = BASE_W'(gbase);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // drive one item, hold it until taken, then queue its expected grant
  task automatic send_item(input req_t r, input bit typed, input grant_t want);
    grant_t g;
    kind <= r.kind;
    page_elems <= r.page_elems;
    format <= r.format;
    pool_slot <= r.pool_slot;
    page_number <= r.page_number;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    g = predict_grant(r);
    pending_grants.insert(pending_grants.size(), typed ? want : g);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic record_fail(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : check_results
    grant_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_grants.size() == 0) begin
          record_fail($sformatf("unexpected result: status=%0d pool=%0d page=%0d base=%0d",
                                status, granted_pool, granted_page, base_index));
        end else begin
          want = pending_grants.pop_front();
          if (status !== want.status || granted_pool !== want.pool ||
              granted_page !== want.page || base_index !== want.base)
            record_fail($sformatf(
              "mismatch: exp status=%0d pool=%0d page=%0d base=%0d, got %0d %0d %0d %0d",
              want.status, want.pool, want.page, want.base,
              status, granted_pool, granted_page, base_index));
        end
      end
      if ((start && !busy) || done === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    req_t   r;
    grant_t none;
    int     i;
    int     gap;
    none.status = ST_OK;
    none.pool = '0;
    none.page = '0;
    none.base = '0;

    // kind, size, format, slot, page, typed, status, pool, page, base
    add_row(KIND_FREE,  0,   0,      0, 0,   1, ST_BAD_FREE, 0, 0,   0);
    add_row(KIND_ALLOC, 0,   0,      5, 9,   1, ST_BAD_SIZE, 0, 0,   0);
    add_row(KIND_ALLOC, 257, 1,      0, 0,   1, ST_BAD_SIZE, 0, 0,   0);
    add_row(KIND_ALLOC, 511, 16'hFFFF, 7, 255, 1, ST_BAD_SIZE, 0, 0, 0);
    add_row(KIND_ALLOC, 256, 0,      0, 0,   1, ST_OK,       0, 0,   0);
    add_row(KIND_ALLOC, 256, 0,      0, 0,   1, ST_OK,       1, 0,   0);
    add_row(KIND_FREE,  0,   0,      0, 0,   1, ST_OK,       0, 0,   0);
    add_row(KIND_FREE,  0,   0,      0, 0,   1, ST_BAD_FREE, 0, 0,   0);
    add_row(KIND_FREE,  0,   0,      0, 1,   1, ST_BAD_FREE, 0, 0,   0);
    add_row(KIND_ALLOC, 1,   16'hFFFF, 0, 0, 1, ST_OK,       2, 255, 255);
    add_row(KIND_ALLOC, 1,   16'hFFFF, 0, 0, 1, ST_OK,       2, 254, 254);
    add_row(KIND_FREE,  0,   0,      2, 255, 1, ST_OK,       0, 0,   0);
    add_row(KIND_FREE,  0,   0,      7, 255, 1, ST_BAD_FREE, 0, 0,   0);
    add_row(KIND_ALLOC, 3,   16'h1234, 0, 0, 0, ST_OK,       0, 0,   0);
    add_row(KIND_ALLOC, 100, 16'hAAAA, 0, 0, 0, ST_OK,       0, 0,   0);
    add_row(KIND_ALLOC, 100, 16'h5555, 0, 0, 0, ST_OK,       0, 0,   0);
    add_row(KIND_ALLOC, 7,   0,      0, 0,   0, ST_OK,       0, 0,   0);
    add_row(KIND_ALLOC, 128, 16'h8000, 0, 0, 0, ST_OK,       0, 0,   0);
    add_row(KIND_ALLOC, 2,   1,      0, 0,   1, ST_NO_SLOT,  0, 0,   0);
    add_row(KIND_ALLOC, 256, 0,      0, 0,   1, ST_OK,       0, 0,   0);
    add_row(KIND_ALLOC, 1,   16'hFFFF, 0, 0, 1, ST_OK,       2, 255, 255);
    add_row(KIND_FREE,  0,   0,      4, 0,   0, ST_OK,       0, 0,   0);
    add_row(KIND_FREE,  0,   0,      4, 0,   1, ST_BAD_FREE, 0, 0,   0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
      idle_for(pick_gap());
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      r = random_req();
      send_item(r, 1'b0, none);
      if (i == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (pending_grants.size() != 0) @(posedge clk);
      end else begin
        gap = ((i % 100) >= 70) ? 0 : pick_gap();
        idle_for(gap);
      end
    end

    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kppa_pkg.sv
sv/kppa_div.sv
sv/kppa_dp.sv
sv/kppa_ctrl.sv
sv/keyed_pool_page_allocator.sv
sv/kppa_checker.sv
dv/tb.sv
